/* rtl/core/qrrs_pkg.sv */
package qrrs_pkg;

  localparam int BYTE_W         = 8;
  localparam int EC_W           = 5;
  localparam int MAX_PARITY_DEF = 30;
  localparam int RESULT_CAP     = 30;

  localparam logic [EC_W-1:0]   EC_LEN_RST = EC_W'(10);
  localparam logic [8:0]        FIELD_POLY = 9'h11D;
  localparam logic [BYTE_W-1:0] GF_ONE     = 8'h01;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              last_data;
  } in_beat_t;

  typedef struct packed {
    logic [BYTE_W-1:0] parity_byte;
    logic              last_parity;
  } out_beat_t;

  typedef struct packed {
    logic [EC_W-1:0] ec_len;
  } cfg_beat_t;

  // remainder register control
  typedef struct packed {
    logic absorb;  // fold the held byte in
    logic last;    // held byte closes the block
    logic clear;   // drop the remainder
  } lfsr_ctl_t;

  // parity buffer control
  typedef struct packed {
    logic            load;
    logic [EC_W-1:0] len;
  } buf_ctl_t;

  typedef enum logic {
    GEN_IDLE,
    GEN_RUN
  } gen_state_t;

  // multiply by alpha
  function automatic logic [BYTE_W-1:0] gf_xtime(input logic [BYTE_W-1:0] a);
    return {a[BYTE_W-2:0], 1'b0} ^ (a[BYTE_W-1] ? FIELD_POLY[BYTE_W-1:0] : '0);
  endfunction

  function automatic logic [BYTE_W-1:0] gf_mul(input logic [BYTE_W-1:0] a_in,
                                               input logic [BYTE_W-1:0] b_in);
    logic [BYTE_W-1:0] a;
    logic [BYTE_W-1:0] acc;
    a   = a_in;
    acc = '0;
    for (int k = 0; k < BYTE_W; k++) begin
      if (b_in[k]) acc = acc ^ a;
      a = gf_xtime(a);
    end
    return acc;
  endfunction

endpackage

/* rtl/core/qrrs_stream_if.sv */
interface qrrs_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

/* rtl/core/qr_reed_solomon_parity_encoder.sv */
// Channel | Dir | Beat payload                 | Notes
// in_ch   | in  | data_byte[7:0], last_data    | one message byte per beat
// out_ch  | out | parity_byte[7:0], last_parity| ec_len beats per block, high degree first
// cfg_ch  | in  | ec_len[4:0]                  | always ready; 0 reads as 1, clamps at 30
//
// Data bytes go in at one per cycle while in_ch is ready; each is registered, then
// folded into the remainder cells once it leaves the input register. A last byte
// moves the finished remainder into the parity buffer, which drains one beat per
// cycle while out_ch is ready. A last byte waits in the input register until the
// previous block's parity is drained or its final beat is being taken. After reset
// and after each ec_len write the generator is rebuilt one root per cycle, with
// in_ch not ready. Reset is synchronous, active low; it also clears the remainder.
module qr_reed_solomon_parity_encoder
  import qrrs_pkg::*;
#(
  parameter int MAX_PARITY = MAX_PARITY_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  qrrs_stream_if.sink   in_ch,
  qrrs_stream_if.source out_ch,
  qrrs_stream_if.sink   cfg_ch
);

  localparam logic [EC_W-1:0] LenLim =
    EC_W'((MAX_PARITY < RESULT_CAP) ? MAX_PARITY : RESULT_CAP);

  // config
  logic [EC_W-1:0] ec_r;
  logic [EC_W-1:0] eff_len;
  logic            cfg_acc;

  // input stage
  logic              in_v_r;
  logic [BYTE_W-1:0] in_data_r;
  logic              in_last_r;
  logic              in_acc;
  logic              consume;

  logic              gen_busy;
  logic              buf_free;
  logic [BYTE_W-1:0] gen     [MAX_PARITY];
  logic [BYTE_W-1:0] rem_upd [MAX_PARITY];
  lfsr_ctl_t         lfsr_ctl;
  buf_ctl_t          buf_ctl;

  assign cfg_ch.ready = 1'b1;
  assign cfg_acc      = cfg_ch.valid && cfg_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ec_r <= EC_LEN_RST;
    end else if (cfg_acc) begin
      ec_r <= cfg_ch.payload.ec_len;
    end
  end

  always_comb begin
    priority if (ec_r == '0) eff_len = EC_W'(1);
    else if (ec_r > LenLim)  eff_len = LenLim;
    else                     eff_len = ec_r;
  end

  // held byte leaves when it is not a block end or the buffer can take parity
  assign consume     = in_v_r && (!in_last_r || buf_free);
  // no data beat on an ec_len write edge: the write drops the input register
  assign in_ch.ready = !gen_busy && !cfg_ch.valid && (!in_v_r || consume);
  assign in_acc      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_acc) begin
      in_v_r <= 1'b0;
    end else if (in_acc) begin
      in_v_r <= 1'b1;
    end else if (consume) begin
      in_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_data_r <= in_ch.payload.data_byte;
      in_last_r <= in_ch.payload.last_data;
    end
  end

  qrrs_gen_build #(.MAX_PARITY(MAX_PARITY)) u_gen (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cfg_acc),
    .eff_len (eff_len),
    .busy    (gen_busy),
    .gen     (gen)
  );

  assign lfsr_ctl.absorb = consume;
  assign lfsr_ctl.last   = in_last_r;
  assign lfsr_ctl.clear  = cfg_acc;

  qrrs_lfsr #(.MAX_PARITY(MAX_PARITY)) u_lfsr (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (lfsr_ctl),
    .data_byte (in_data_r),
    .gen       (gen),
    .rem_upd   (rem_upd)
  );

  assign buf_ctl.load = consume && in_last_r;
  assign buf_ctl.len  = eff_len;

  qrrs_par_buf #(.MAX_PARITY(MAX_PARITY)) u_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (buf_ctl),
    .load_data (rem_upd),
    .free      (buf_free),
    .out_ch    (out_ch)
  );

  a_no_in_during_build: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> !gen_busy)
    else $error("data beat taken while generator is being rebuilt");

  a_cfg_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_acc |=> !in_ch.ready)
    else $error("input ready right after ec_len write");

endmodule

/* rtl/core/qrrs_gen_build.sv */
// Generator builder: multiplies by (x + alpha^i) one root per cycle.
// Coefficients kept highest degree first, leading 1 implicit.
module qrrs_gen_build
  import qrrs_pkg::*;
#(
  parameter int MAX_PARITY = MAX_PARITY_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [EC_W-1:0]   eff_len,
  output logic              busy,
  output logic [BYTE_W-1:0] gen [MAX_PARITY]
);

  gen_state_t        state_r, state_nxt;
  logic [EC_W-1:0]   step_r, step_nxt;
  logic [BYTE_W-1:0] root_r, root_nxt;
  logic [BYTE_W-1:0] gen_r   [MAX_PARITY];
  logic [BYTE_W-1:0] gen_nxt [MAX_PARITY];
  logic [BYTE_W-1:0] prev    [MAX_PARITY];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= GEN_RUN;
      step_r  <= '0;
      root_r  <= GF_ONE;
      for (int j = 0; j < MAX_PARITY; j++) gen_r[j] <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      root_r  <= root_nxt;
      for (int j = 0; j < MAX_PARITY; j++) gen_r[j] <= gen_nxt[j];
    end
  end

  always_comb begin
    prev[0] = GF_ONE;
    for (int j = 1; j < MAX_PARITY; j++) prev[j] = gen_r[j-1];
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    root_nxt  = root_r;
    for (int j = 0; j < MAX_PARITY; j++) gen_nxt[j] = gen_r[j];
    if (start) begin
      state_nxt = GEN_RUN;
      step_nxt  = '0;
      root_nxt  = GF_ONE;
      for (int j = 0; j < MAX_PARITY; j++) gen_nxt[j] = '0;
    end else begin
      unique case (state_r)
        GEN_IDLE: ;
        GEN_RUN: begin
          for (int j = 0; j < MAX_PARITY; j++)
            gen_nxt[j] = gen_r[j] ^ gf_mul(root_r, prev[j]);
          root_nxt = gf_xtime(root_r);
          step_nxt = step_r + EC_W'(1);
          if (step_r == eff_len - EC_W'(1)) state_nxt = GEN_IDLE;
        end
        default: state_nxt = GEN_IDLE;
      endcase
    end
  end

  assign busy = (state_r == GEN_RUN);
  assign gen  = gen_r;

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> busy)
    else $error("builder not running after start");

  a_run_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (busy && !start && step_r == eff_len - EC_W'(1)) |=> !busy)
    else $error("builder overran generator degree");

endmodule

/* rtl/core/qrrs_lfsr.sv */
// Remainder cells, all updated together for each absorbed byte.
module qrrs_lfsr
  import qrrs_pkg::*;
#(
  parameter int MAX_PARITY = MAX_PARITY_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  lfsr_ctl_t         ctl,
  input  logic [BYTE_W-1:0] data_byte,
  input  logic [BYTE_W-1:0] gen     [MAX_PARITY],
  output logic [BYTE_W-1:0] rem_upd [MAX_PARITY]
);

  logic [BYTE_W-1:0] rem_r   [MAX_PARITY];
  logic [BYTE_W-1:0] rem_ext [MAX_PARITY+1];
  logic [BYTE_W-1:0] fb;

  always_comb begin
    for (int j = 0; j < MAX_PARITY; j++) rem_ext[j] = rem_r[j];
    rem_ext[MAX_PARITY] = '0;
    fb = data_byte ^ rem_r[0];
    // cells past the generator degree see zero coefficients and stay zero
    for (int j = 0; j < MAX_PARITY; j++)
      rem_upd[j] = rem_ext[j+1] ^ gf_mul(fb, gen[j]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clear || (ctl.absorb && ctl.last)) begin
      for (int j = 0; j < MAX_PARITY; j++) rem_r[j] <= '0;
    end else if (ctl.absorb) begin
      for (int j = 0; j < MAX_PARITY; j++) rem_r[j] <= rem_upd[j];
    end
  end

endmodule

/* rtl/core/qrrs_par_buf.sv */
// Parity drain buffer: loaded with a whole remainder, shifted out a beat at a time.
module qrrs_par_buf
  import qrrs_pkg::*;
#(
  parameter int MAX_PARITY = MAX_PARITY_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  buf_ctl_t          ctl,
  input  logic [BYTE_W-1:0] load_data [MAX_PARITY],
  output logic              free,
  qrrs_stream_if.source     out_ch
);

  logic [BYTE_W-1:0] buf_r [MAX_PARITY];
  logic [EC_W-1:0]   count_r;
  logic              pop;

  assign pop  = out_ch.valid && out_ch.ready;
  assign free = (count_r == '0) || ((count_r == EC_W'(1)) && pop);

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      for (int j = 0; j < MAX_PARITY; j++) buf_r[j] <= load_data[j];
    end else if (pop) begin
      for (int j = 0; j < MAX_PARITY - 1; j++) buf_r[j] <= buf_r[j+1];
      buf_r[MAX_PARITY-1] <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (ctl.load) begin
      count_r <= ctl.len;
    end else if (pop) begin
      count_r <= count_r - EC_W'(1);
    end
  end

  assign out_ch.valid               = (count_r != '0);
  assign out_ch.payload.parity_byte = buf_r[0];
  assign out_ch.payload.last_parity = (count_r == EC_W'(1));

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.load |-> (count_r == '0 || (count_r == EC_W'(1) && pop)))
    else $error("parity buffer reloaded while still draining");

endmodule

/* tb/sv/tb_top.sv */
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import qrrs_pkg::*;

  // Predictor depth: the clamp ceiling for ec_len.
  localparam int MAXP       = (MAX_PARITY_DEF < RESULT_CAP) ? MAX_PARITY_DEF : RESULT_CAP;
  // Byte is registered, then folded into the remainder; leave slack on top.
  localparam int SETTLE_CYC = 8;
  // End-of-run cap on waiting for outstanding parity beats.
  localparam int DRAIN_CAP  = 20000;
  localparam int N_DIR      = 24;

  logic clk;
  logic rst_n;

  qrrs_stream_if #(.payload_t(in_beat_t))  in_ch  ();
  qrrs_stream_if #(.payload_t(out_beat_t)) out_ch ();
  qrrs_stream_if #(.payload_t(cfg_beat_t)) cfg_ch ();

  qr_reed_solomon_parity_encoder i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // ---------------------------------------------------------------------------
  // Clock, and a hard stop in case the block hangs.
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Encoder predictor: GF(256) over 0x11D via log/antilog tables, generator
  // taps held highest degree first, and an LFSR remainder of eff_len cells.
  // ---------------------------------------------------------------------------
  logic [7:0]  alog_tbl [0:254];
  int unsigned log_tbl  [0:255];
  logic [7:0]  rem_cells [MAXP];
  logic [7:0]  gen_taps  [MAXP];
  int unsigned eff_len;

  // Parity beats still owed by the block, oldest first.
  out_beat_t   parity_q [$];

  int          mism;
  int          src_idle_pct;
  int          snk_idle_pct;

  function automatic void build_log_tables();
    logic [7:0] x;
    x = 8'h01;
    for (int i = 0; i < 255; i++) begin
      alog_tbl[i] = x;
      log_tbl[x]  = i;
      // multiply by alpha; reduce with the low byte of 0x11D
      x = {x[6:0], 1'b0} ^ (x[7] ? 8'h1D : 8'h00);
    end
  endfunction

  function automatic logic [7:0] gf_times(input logic [7:0] a, input logic [7:0] b);
    if (a == 8'h00 || b == 8'h00) return 8'h00;
    return alog_tbl[(log_tbl[a] + log_tbl[b]) % 255];
  endfunction

  // New ec_len: clamp, rebuild g(x) = prod (x + alpha^i), drop the remainder.
  function automatic void load_ec_len(input logic [EC_W-1:0] v);
    logic [7:0]  poly [MAXP+1];
    logic [7:0]  root;
    int unsigned n;
    n = (v == '0) ? 1 : int'(v);
    if (n > MAXP) n = MAXP;
    eff_len = n;
    foreach (poly[k]) poly[k] = 8'h00;
    poly[0] = 8'h01;
    root    = 8'h01;
    for (int i = 0; i < n; i++) begin
      for (int j = i + 1; j > 0; j--)
        poly[j] = poly[j-1] ^ gf_times(poly[j], root);
      poly[0] = gf_times(poly[0], root);
      root    = gf_times(root, 8'h02);
    end
    foreach (gen_taps[k])  gen_taps[k]  = 8'h00;
    foreach (rem_cells[k]) rem_cells[k] = 8'h00;
    for (int j = 0; j < n; j++) gen_taps[j] = poly[n-1-j];
  endfunction

  // Fold one message byte into the remainder; on the last byte hand back the
  // parity beats, highest degree first, and clear for the next block.
  function automatic void absorb_byte(input logic [7:0] d, input logic last,
                                      output out_beat_t res [$]);
    logic [7:0] fb;
    out_beat_t  pb;
    res = {};
    fb  = d ^ rem_cells[0];
    for (int j = 0; j + 1 < eff_len; j++)
      rem_cells[j] = rem_cells[j+1] ^ gf_times(fb, gen_taps[j]);
    rem_cells[eff_len-1] = gf_times(fb, gen_taps[eff_len-1]);
    if (last) begin
      for (int j = 0; j < eff_len; j++) begin
        pb.parity_byte = rem_cells[j];
        pb.last_parity = (j + 1 == eff_len);
        res.push_back(pb);
      end
      foreach (rem_cells[k]) rem_cells[k] = 8'h00;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Output side: random ready, and the in-order check of every parity beat.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
  end

  always @(posedge clk) begin : parity_mon
    out_beat_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (parity_q.size() == 0) begin
        mism++;
        if (mism <= 10)
          $display("%0t: parity beat with none owed: byte %02h last %0b",
                   $realtime, out_ch.payload.parity_byte, out_ch.payload.last_parity);
      end else begin
        want = parity_q.pop_front();
        if (out_ch.payload !== want) begin
          mism++;
          if (mism <= 10)
            $display("%0t: parity mismatch: want byte %02h last %0b, got byte %02h last %0b",
                     $realtime, want.parity_byte, want.last_parity,
                     out_ch.payload.parity_byte, out_ch.payload.last_parity);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Input side.
  // ---------------------------------------------------------------------------

  // One message beat. Each idle cycle drops valid; otherwise valid stays high
  // straight from the previous beat. Typed rows supply their own parity.
  task automatic send_byte(input logic [7:0] d, input logic last, input logic typed,
                           input int exp_n, input logic [7:0] exp_b);
    out_beat_t res [$];
    out_beat_t pb;
    in_beat_t  beat;
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    beat.data_byte = d;
    beat.last_data = last;
    in_ch.valid   <= 1'b1;
    in_ch.payload <= beat;
    do @(posedge clk); while (!in_ch.ready);
    absorb_byte(d, last, res);
    if (typed && last) begin
      for (int i = 0; i < exp_n; i++) begin
        pb.parity_byte = exp_b;
        pb.last_parity = (i == exp_n - 1);
        parity_q.push_back(pb);
      end
    end else begin
      foreach (res[i]) parity_q.push_back(res[i]);
    end
  endtask

  // Hold off until all owed parity is out, then let the pipeline settle so a
  // trailing non-last byte is folded before anything else happens.
  task automatic wait_parity_drained();
    in_ch.valid <= 1'b0;
    while (parity_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  // ec_len write, only with the block idle. The generator rebuild that
  // follows is covered by in_ch back-pressure.
  task automatic write_ec_len(input logic [EC_W-1:0] v);
    cfg_beat_t c;
    wait_parity_drained();
    c.ec_len       = v;
    cfg_ch.valid   <= 1'b1;
    cfg_ch.payload <= c;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid   <= 1'b0;
    load_ec_len(v);
  endtask

  function automatic logic [EC_W-1:0] pick_ec_len();
    case ($urandom_range(0, 5))
      0:       return '0;          // reads as 1
      1:       return '1;          // 31, clamps to 30
      2:       return EC_W'(30);
      3:       return EC_W'(1);
      default: return EC_W'($urandom_range(0, 31));
    endcase
  endfunction

  // Random blocks of random bytes; mostly short blocks, a few long ones,
  // an occasional ec_len change between blocks and, rarely, mid-block.
  task automatic run_random(input int src_pct, input int snk_pct, input int n_items);
    int sent;
    int blen;
    int cut;
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    write_ec_len(pick_ec_len());
    sent = 0;
    while (sent < n_items) begin
      blen = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6);
      cut  = (blen > 1 && $urandom_range(0, 9) == 0) ? $urandom_range(1, blen - 1) : -1;
      for (int k = 0; k < blen; k++) begin
        if (k == cut) write_ec_len(pick_ec_len());
        send_byte(8'($urandom_range(0, 255)), (k == blen - 1), 1'b0, 0, 8'h00);
        sent++;
      end
      if ($urandom_range(0, 3) == 0) write_ec_len(pick_ec_len());
    end
  endtask

  // ---------------------------------------------------------------------------
  // Directed table. Typed rows: all-zero message gives all-zero parity;
  // with ec_len 1 the generator is x+1, so the parity is the XOR of the block.
  // ---------------------------------------------------------------------------
  typedef enum logic {
    ROW_CFG,
    ROW_BYTE
  } row_kind_e;

  typedef struct packed {
    row_kind_e  kind;
    logic [7:0] val;      // data byte, or ec_len in [4:0]
    logic       last;
    logic       typed;
    logic [5:0] exp_n;
    logic [7:0] exp_byte;
  } stim_row_t;

  stim_row_t dir_tbl [N_DIR] = '{
    '{ROW_BYTE, 8'h00, 1'b1, 1'b1, 6'd10, 8'h00},  // reset generator, zero block
    '{ROW_BYTE, 8'hFF, 1'b0, 1'b0, 6'd0,  8'h00},
    '{ROW_BYTE, 8'h00, 1'b0, 1'b0, 6'd0,  8'h00},
    '{ROW_BYTE, 8'h80, 1'b1, 1'b0, 6'd0,  8'h00},
    '{ROW_CFG,  8'h00, 1'b0, 1'b0, 6'd0,  8'h00},  // zero reads as 1
    '{ROW_BYTE, 8'hA5, 1'b1, 1'b1, 6'd1,  8'hA5},
    '{ROW_BYTE, 8'h0F, 1'b0, 1'b0, 6'd0,  8'h00},
    '{ROW_BYTE, 8'hF0, 1'b1, 1'b1, 6'd1,  8'hFF},
    '{ROW_CFG,  8'h1F, 1'b0, 1'b0, 6'd0,  8'h00},  // above limit, saturates to 30
    '{ROW_BYTE, 8'h00, 1'b1, 1'b1, 6'd30, 8'h00},
    '{ROW_BYTE, 8'hFF, 1'b1, 1'b0, 6'd0,  8'h00},
    '{ROW_BYTE, 8'h55, 1'b0, 1'b0, 6'd0,  8'h00},
    '{ROW_BYTE, 8'hAA, 1'b1, 1'b0, 6'd0,  8'h00},
    '{ROW_CFG,  8'h1E, 1'b0, 1'b0, 6'd0,  8'h00},
    '{ROW_BYTE, 8'h01, 1'b1, 1'b0, 6'd0,  8'h00},
    '{ROW_CFG,  8'h02, 1'b0, 1'b0, 6'd0,  8'h00},
    '{ROW_BYTE, 8'h7E, 1'b0, 1'b0, 6'd0,  8'h00},
    '{ROW_BYTE, 8'h81, 1'b1, 1'b0, 6'd0,  8'h00},
    '{ROW_BYTE, 8'h12, 1'b0, 1'b0, 6'd0,  8'h00},  // block cut short by the write below
    '{ROW_BYTE, 8'h34, 1'b0, 1'b0, 6'd0,  8'h00},
    '{ROW_CFG,  8'h0A, 1'b0, 1'b0, 6'd0,  8'h00},
    '{ROW_BYTE, 8'h56, 1'b1, 1'b0, 6'd0,  8'h00},
    '{ROW_CFG,  8'h01, 1'b0, 1'b0, 6'd0,  8'h00},
    '{ROW_BYTE, 8'hC3, 1'b1, 1'b1, 6'd1,  8'hC3}
  };

  // ---------------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------------
  initial begin
    int waited;
    mism         = 0;
    src_idle_pct = 16;
    snk_idle_pct = 50;
    rst_n          <= 1'b0;
    in_ch.valid    <= 1'b0;
    in_ch.payload  <= '0;
    cfg_ch.valid   <= 1'b0;
    cfg_ch.payload <= '0;
    build_log_tables();
    load_ec_len(EC_LEN_RST);
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_tbl[r]) begin
      if (dir_tbl[r].kind == ROW_CFG)
        write_ec_len(dir_tbl[r].val[EC_W-1:0]);
      else
        send_byte(dir_tbl[r].val, dir_tbl[r].last, dir_tbl[r].typed,
                  int'(dir_tbl[r].exp_n), dir_tbl[r].exp_byte);
    end

    // sender light / receiver heavy, then swapped, then flat out
    run_random(16, 50, 28);
    run_random(50, 16, 28);
    run_random(0, 0, 28);

    in_ch.valid <= 1'b0;
    waited = 0;
    while (parity_q.size() != 0 && waited < DRAIN_CAP) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYC * 4) @(posedge clk);
    if (parity_q.size() != 0) begin
      $display("%0d parity beats never arrived", parity_q.size());
      mism += parity_q.size();
    end

    if (mism == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

`default_nettype wire
